/* design/apsm_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// apsm_pkg
// Shared types, constants and helpers of the axis position settle monitor.
// ----------------------------------------------------------------------------
package apsm_pkg;

	// axis store and field widths
	localparam int MAX_AXES = 8;
	localparam int AXIS_W   = $clog2(MAX_AXES);
	localparam int POS_W    = 20;
	localparam int ACT_W    = 21;
	localparam int TIMER_W  = 17;
	localparam int BAND_W   = 14;
	localparam int CNT_W    = 4;

	// band arithmetic: factor width holds 10000 plus the widest band, signed
	localparam int FACT_W = 16;
	localparam int PROD_W = ACT_W + FACT_W;
	localparam logic signed [FACT_W-1:0] BAND_SCALE = 16'sd10000;

	// timers stop counting here
	localparam logic [TIMER_W-1:0] TIMER_LIMIT = 17'd99990;

	// configuration port
	localparam int ADDR_W = 5;
	localparam int DATA_W = 32;

	typedef enum logic [2:0] {
		REG_AXIS_COUNT    = 3'd0,
		REG_CHANGE_DELAY  = 3'd1,
		REG_STABLE_TIME   = 3'd2,
		REG_FAULT_TIMEOUT = 3'd3,
		REG_WARNING_BAND  = 3'd4,
		REG_FAULT_BAND    = 3'd5
	} reg_idx_t;

	// register reset values
	localparam logic [CNT_W-1:0]   AXIS_COUNT_RST    = 4'd1;
	localparam logic [TIMER_W-1:0] CHANGE_DELAY_RST  = 17'd0;
	localparam logic [TIMER_W-1:0] STABLE_TIME_RST   = 17'd10;
	localparam logic [TIMER_W-1:0] FAULT_TIMEOUT_RST = 17'd50;
	localparam logic [BAND_W-1:0]  BAND_RST          = 14'd0;

	typedef struct packed {
		logic [CNT_W-1:0]   axis_count;
		logic [TIMER_W-1:0] change_delay_ticks;
		logic [TIMER_W-1:0] stable_time_ticks;
		logic [TIMER_W-1:0] fault_timeout_ticks;
		logic [BAND_W-1:0]  warning_band;
		logic [BAND_W-1:0]  fault_band;
	} cfg_t;

	// saturating tick counter step
	function automatic logic [TIMER_W-1:0] sat_inc(input logic [TIMER_W-1:0] v);
		sat_inc = (v >= TIMER_LIMIT) ? TIMER_LIMIT : v + TIMER_W'(1);
	endfunction

endpackage
`default_nettype wire

/* design/apsm_cfg_regs.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// apsm_cfg_regs
// Register file behind the APB-style configuration port.
// ----------------------------------------------------------------------------
module apsm_cfg_regs (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [apsm_pkg::ADDR_W-1:0]   paddr,
	input  wire logic [apsm_pkg::DATA_W-1:0]   pwdata,
	output logic      [apsm_pkg::DATA_W-1:0]   prdata,
	output logic                               pready,
	output apsm_pkg::cfg_t                     cfg
);

	apsm_pkg::cfg_t cfg_q;
	logic           wr_en;
	logic [2:0]     reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite;
	assign reg_idx = paddr[apsm_pkg::ADDR_W-1:2];
	assign cfg     = cfg_q;

	// register writes, indexes beyond the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.axis_count          <= apsm_pkg::AXIS_COUNT_RST;
			cfg_q.change_delay_ticks  <= apsm_pkg::CHANGE_DELAY_RST;
			cfg_q.stable_time_ticks   <= apsm_pkg::STABLE_TIME_RST;
			cfg_q.fault_timeout_ticks <= apsm_pkg::FAULT_TIMEOUT_RST;
			cfg_q.warning_band        <= apsm_pkg::BAND_RST;
			cfg_q.fault_band          <= apsm_pkg::BAND_RST;
		end else if (wr_en) begin
			unique case (reg_idx)
				apsm_pkg::REG_AXIS_COUNT:
					cfg_q.axis_count <= pwdata[apsm_pkg::CNT_W-1:0];
				apsm_pkg::REG_CHANGE_DELAY:
					cfg_q.change_delay_ticks <= pwdata[apsm_pkg::TIMER_W-1:0];
				apsm_pkg::REG_STABLE_TIME:
					cfg_q.stable_time_ticks <= pwdata[apsm_pkg::TIMER_W-1:0];
				apsm_pkg::REG_FAULT_TIMEOUT:
					cfg_q.fault_timeout_ticks <= pwdata[apsm_pkg::TIMER_W-1:0];
				apsm_pkg::REG_WARNING_BAND:
					cfg_q.warning_band <= pwdata[apsm_pkg::BAND_W-1:0];
				apsm_pkg::REG_FAULT_BAND:
					cfg_q.fault_band <= pwdata[apsm_pkg::BAND_W-1:0];
				default: ;
			endcase
		end
	end

	// read mux
	always_comb begin
		prdata = '0;
		unique case (reg_idx)
			apsm_pkg::REG_AXIS_COUNT:
				prdata = apsm_pkg::DATA_W'(cfg_q.axis_count);
			apsm_pkg::REG_CHANGE_DELAY:
				prdata = apsm_pkg::DATA_W'(cfg_q.change_delay_ticks);
			apsm_pkg::REG_STABLE_TIME:
				prdata = apsm_pkg::DATA_W'(cfg_q.stable_time_ticks);
			apsm_pkg::REG_FAULT_TIMEOUT:
				prdata = apsm_pkg::DATA_W'(cfg_q.fault_timeout_ticks);
			apsm_pkg::REG_WARNING_BAND:
				prdata = apsm_pkg::DATA_W'(cfg_q.warning_band);
			apsm_pkg::REG_FAULT_BAND:
				prdata = apsm_pkg::DATA_W'(cfg_q.fault_band);
			default:
				prdata = '0;
		endcase
	end

endmodule
`default_nettype wire

/* design/apsm_band_chk.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// apsm_band_chk
// Tolerance band check: scaled products registered, strict compares after.
// ----------------------------------------------------------------------------
module apsm_band_chk (
	input  wire logic                                clk,
	input  wire logic                                en,
	input  wire logic        [apsm_pkg::POS_W-1:0]   target_pos,
	input  wire logic signed [apsm_pkg::ACT_W-1:0]   actual_pos,
	input  wire apsm_pkg::cfg_t                      cfg,
	output logic                                     band_fail
);

	logic signed [apsm_pkg::ACT_W-1:0]  tgt_x;
	logic signed [apsm_pkg::FACT_W-1:0] warn_lo_k, warn_hi_k, fault_lo_k, fault_hi_k;
	logic signed [apsm_pkg::PROD_W-1:0] act_p, warn_lo_p, warn_hi_p, fault_lo_p, fault_hi_p;
	logic signed [apsm_pkg::PROD_W-1:0] act_s2, warn_lo_s2, warn_hi_s2, fault_lo_s2, fault_hi_s2;
	logic                               warn_fail, fault_fail;

	// bound factors 10000 -/+ band, lower one may go negative
	assign warn_lo_k  = apsm_pkg::BAND_SCALE
		- $signed({2'b00, cfg.warning_band});
	assign warn_hi_k  = apsm_pkg::BAND_SCALE
		+ $signed({2'b00, cfg.warning_band});
	assign fault_lo_k = apsm_pkg::BAND_SCALE
		- $signed({2'b00, cfg.fault_band});
	assign fault_hi_k = apsm_pkg::BAND_SCALE
		+ $signed({2'b00, cfg.fault_band});

	// setpoint is nonnegative, zero extended into signed math
	assign tgt_x = $signed({1'b0, target_pos});

	// independent products, one multiplier each
	assign act_p      = actual_pos * apsm_pkg::BAND_SCALE;
	assign warn_lo_p  = tgt_x * warn_lo_k;
	assign warn_hi_p  = tgt_x * warn_hi_k;
	assign fault_lo_p = tgt_x * fault_lo_k;
	assign fault_hi_p = tgt_x * fault_hi_k;

	always_ff @(posedge clk) begin
		if (en) begin
			act_s2      <= act_p;
			warn_lo_s2  <= warn_lo_p;
			warn_hi_s2  <= warn_hi_p;
			fault_lo_s2 <= fault_lo_p;
			fault_hi_s2 <= fault_hi_p;
		end
	end

	// strict bounds, zero band disables
	assign warn_fail  = (cfg.warning_band != '0)
		&& ((act_s2 < warn_lo_s2) || (act_s2 > warn_hi_s2));
	assign fault_fail = (cfg.fault_band != '0)
		&& ((act_s2 < fault_lo_s2) || (act_s2 > fault_hi_s2));
	assign band_fail  = warn_fail | fault_fail;

endmodule
`default_nettype wire

/* design/apsm_axis_state.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// apsm_axis_state
// Per-axis timers and flags, combinational update into the state store, result register.
// ----------------------------------------------------------------------------
module apsm_axis_state (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               en,
	input  wire logic                               item_valid,
	input  wire logic [apsm_pkg::AXIS_W-1:0]        item_axis,
	input  wire logic [apsm_pkg::POS_W-1:0]         item_target,
	input  wire logic                               band_fail,
	input  wire apsm_pkg::cfg_t                     cfg,
	output logic                                    result_valid,
	output logic [apsm_pkg::AXIS_W-1:0]             axis_out,
	output logic                                    settle_done,
	output logic                                    out_of_band,
	output logic                                    axis_stable,
	output logic                                    axis_fault,
	output logic                                    all_stable,
	output logic                                    any_fault
);

	// per-axis state
	logic [apsm_pkg::POS_W-1:0]   last_target_q  [apsm_pkg::MAX_AXES];
	logic [apsm_pkg::TIMER_W-1:0] settle_timer_q [apsm_pkg::MAX_AXES];
	logic [apsm_pkg::TIMER_W-1:0] stable_timer_q [apsm_pkg::MAX_AXES];
	logic [apsm_pkg::TIMER_W-1:0] fault_timer_q  [apsm_pkg::MAX_AXES];
	logic [apsm_pkg::MAX_AXES-1:0] running_q, settled_q, stable_q, fault_q;

	// next values of the addressed axis
	logic [apsm_pkg::TIMER_W-1:0] settle_nx, stable_tmr_nx, fault_tmr_nx, settle_adv;
	logic                         running_nx, settled_nx, stable_nx, fault_nx;
	logic                         changed, checked, oob_nx;
	logic [apsm_pkg::MAX_AXES-1:0] stable_vec, fault_vec, in_use;
	logic                         all_stable_nx, any_fault_nx;
	logic                         upd;

	// result register
	logic                          result_valid_q;
	logic [apsm_pkg::AXIS_W-1:0]   axis_q;
	logic                          settle_done_q, oob_q, stable_out_q, fault_out_q;
	logic                          all_stable_q, any_fault_q;

	assign upd = en & item_valid;

	// tick update for the addressed axis
	always_comb begin
		settle_nx     = settle_timer_q[item_axis];
		stable_tmr_nx = stable_timer_q[item_axis];
		fault_tmr_nx  = fault_timer_q[item_axis];
		running_nx    = running_q[item_axis];
		settled_nx    = settled_q[item_axis];
		stable_nx     = stable_q[item_axis];
		fault_nx      = fault_q[item_axis];
		checked       = 1'b0;
		oob_nx        = 1'b0;
		changed       = last_target_q[item_axis] != item_target;
		settle_adv    = running_q[item_axis] ? apsm_pkg::sat_inc(settle_timer_q[item_axis])
			: settle_timer_q[item_axis];

		if (changed) begin
			// new setpoint restarts the settle delay
			settle_nx     = '0;
			running_nx    = 1'b1;
			settled_nx    = 1'b0;
			stable_tmr_nx = '0;
			stable_nx     = 1'b0;
			fault_tmr_nx  = '0;
			fault_nx      = 1'b0;
		end else if (settled_q[item_axis]) begin
			checked = 1'b1;
		end else if (cfg.change_delay_ticks <= settle_adv) begin
			settle_nx  = '0;
			running_nx = 1'b0;
			settled_nx = 1'b1;
			checked    = 1'b1;
		end else begin
			settle_nx = settle_adv;
		end

		if (checked) begin
			if (band_fail) begin
				oob_nx = 1'b1;
				if (cfg.fault_timeout_ticks <= fault_timer_q[item_axis]) begin
					fault_tmr_nx = '0;
					fault_nx     = 1'b1;
				end else begin
					fault_tmr_nx = apsm_pkg::sat_inc(fault_timer_q[item_axis]);
				end
				stable_tmr_nx = '0;
				stable_nx     = 1'b0;
			end else begin
				if (cfg.stable_time_ticks <= stable_timer_q[item_axis]) begin
					stable_tmr_nx = '0;
					stable_nx     = 1'b1;
				end else begin
					stable_tmr_nx = apsm_pkg::sat_inc(stable_timer_q[item_axis]);
				end
				fault_tmr_nx = '0;
				fault_nx     = 1'b0;
			end
		end
	end

	// summaries over axes in use, with this tick's flags merged in
	always_comb begin
		stable_vec            = stable_q;
		fault_vec             = fault_q;
		stable_vec[item_axis] = stable_nx;
		fault_vec[item_axis]  = fault_nx;
		for (int i = 0; i < apsm_pkg::MAX_AXES; i++) begin
			in_use[i] = apsm_pkg::CNT_W'(i) < cfg.axis_count;
		end
		all_stable_nx = &(stable_vec | ~in_use);
		any_fault_nx  = |(fault_vec & in_use);
	end

	// state store
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < apsm_pkg::MAX_AXES; i++) begin
				last_target_q[i]  <= '0;
				settle_timer_q[i] <= '0;
				stable_timer_q[i] <= '0;
				fault_timer_q[i]  <= '0;
			end
			running_q <= '0;
			settled_q <= '0;
			stable_q  <= '0;
			fault_q   <= '0;
		end else if (upd) begin
			last_target_q[item_axis]  <= item_target;
			settle_timer_q[item_axis] <= settle_nx;
			stable_timer_q[item_axis] <= stable_tmr_nx;
			fault_timer_q[item_axis]  <= fault_tmr_nx;
			running_q[item_axis]      <= running_nx;
			settled_q[item_axis]      <= settled_nx;
			stable_q[item_axis]       <= stable_nx;
			fault_q[item_axis]        <= fault_nx;
		end
	end

	// result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (en) begin
			result_valid_q <= item_valid;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (upd) begin
			axis_q        <= item_axis;
			settle_done_q <= settled_nx;
			oob_q         <= oob_nx;
			stable_out_q  <= stable_nx;
			fault_out_q   <= fault_nx;
			all_stable_q  <= all_stable_nx;
			any_fault_q   <= any_fault_nx;
		end
	end

	assign result_valid = result_valid_q;
	assign axis_out     = axis_q;
	assign settle_done  = settle_done_q;
	assign out_of_band  = oob_q;
	assign axis_stable  = stable_out_q;
	assign axis_fault   = fault_out_q;
	assign all_stable   = all_stable_q;
	assign any_fault    = any_fault_q;

`ifndef SYNTHESIS
	// an axis is never stable and faulted at once
	a_stable_fault_excl: assert property (@(posedge clk) disable iff (!arst_n)
		(stable_q & fault_q) == '0)
		else $error("axis both stable and faulted");

	// stable or fault only after the settle delay has passed
	a_flags_need_settle: assert property (@(posedge clk) disable iff (!arst_n)
		((stable_q | fault_q) & ~settled_q) == '0)
		else $error("flag set on unsettled axis");

	// settle timer stops once the axis is settled
	a_running_not_settled: assert property (@(posedge clk) disable iff (!arst_n)
		(running_q & settled_q) == '0)
		else $error("settle timer running on settled axis");

	// an out-of-band result comes from a settled, non-stable axis
	a_oob_result: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q && oob_q |-> settle_done_q && !stable_out_q)
		else $error("out of band on unsettled or stable result");

	// a new setpoint is reported with all flags clear
	a_change_clears: assert property (@(posedge clk) disable iff (!arst_n)
		upd && changed |=> !settle_done_q && !stable_out_q && !fault_out_q && !oob_q)
		else $error("setpoint change left a flag set");
`endif

endmodule
`default_nettype wire

/* design/axis_position_settle_monitor.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// axis_position_settle_monitor
// Per-axis settle, stable and fault tracking of position monitor ticks.
// ----------------------------------------------------------------------------
//  channel  handshake                 payload
//  tick     tick_valid / tick_stall   axis, target_pos, actual_pos
//  result   result_valid / result_stall
//                                     axis_out, settle_done, out_of_band,
//                                     axis_stable, axis_fault, all_stable,
//                                     any_fault
//  config   APB (psel, penable, ...)  six registers at byte address 4*i
//
// one item per cycle while no stalled result is held; an item passes the
// input register, band products register, then the per-axis update that writes
// the result register. Per-axis state is read and written in that last stage,
// so ticks for the same axis may follow each other with no gap between them.
// A stalled result freezes the whole pipe; tick_stall follows result_stall
// while a result is held. Reset clears all axis state and loads register
// defaults, no clearing pass.
// ----------------------------------------------------------------------------
module axis_position_settle_monitor (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	// tick channel
	input  wire logic                                tick_valid,
	output logic                                     tick_stall,
	input  wire logic        [apsm_pkg::AXIS_W-1:0]  axis,
	input  wire logic        [apsm_pkg::POS_W-1:0]   target_pos,
	input  wire logic signed [apsm_pkg::ACT_W-1:0]   actual_pos,
	// result channel
	output logic                                     result_valid,
	input  wire logic                                result_stall,
	output logic             [apsm_pkg::AXIS_W-1:0]  axis_out,
	output logic                                     settle_done,
	output logic                                     out_of_band,
	output logic                                     axis_stable,
	output logic                                     axis_fault,
	output logic                                     all_stable,
	output logic                                     any_fault,
	// configuration port
	input  wire logic                                psel,
	input  wire logic                                penable,
	input  wire logic                                pwrite,
	input  wire logic        [apsm_pkg::ADDR_W-1:0]  paddr,
	input  wire logic        [apsm_pkg::DATA_W-1:0]  pwdata,
	output logic             [apsm_pkg::DATA_W-1:0]  prdata,
	output logic                                     pready
);

	apsm_pkg::cfg_t cfg;
	logic           en;
	logic           band_fail;

	logic                               valid_s1, valid_s2;
	logic        [apsm_pkg::AXIS_W-1:0] axis_s1, axis_s2;
	logic        [apsm_pkg::POS_W-1:0]  target_s1, target_s2;
	logic signed [apsm_pkg::ACT_W-1:0]  actual_s1;

	// pipe advances unless a finished result is held
	assign en         = !(result_valid && result_stall);
	assign tick_stall = !en;

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s1 <= tick_valid;
			valid_s2 <= valid_s1;
		end
	end

	// stage payloads
	always_ff @(posedge clk) begin
		if (en) begin
			axis_s1   <= axis;
			target_s1 <= target_pos;
			actual_s1 <= actual_pos;
			axis_s2   <= axis_s1;
			target_s2 <= target_s1;
		end
	end

	apsm_cfg_regs u_cfg_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	apsm_band_chk u_band_chk (
		.clk        (clk),
		.en         (en),
		.target_pos (target_s1),
		.actual_pos (actual_s1),
		.cfg        (cfg),
		.band_fail  (band_fail)
	);

	apsm_axis_state u_axis_state (
		.clk          (clk),
		.arst_n       (arst_n),
		.en           (en),
		.item_valid   (valid_s2),
		.item_axis    (axis_s2),
		.item_target  (target_s2),
		.band_fail    (band_fail),
		.cfg          (cfg),
		.result_valid (result_valid),
		.axis_out     (axis_out),
		.settle_done  (settle_done),
		.out_of_band  (out_of_band),
		.axis_stable  (axis_stable),
		.axis_fault   (axis_fault),
		.all_stable   (all_stable),
		.any_fault    (any_fault)
	);

endmodule
`default_nettype wire

/* test/settle_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// settle_checker
// Watches the tick, result and configuration channels of the settle monitor,
// keeps its own copy of the per-axis timers and flags, predicts the status of
// every accepted tick and compares it field by field with the result stream.
// ----------------------------------------------------------------------------
module settle_checker
	import apsm_pkg::*;
(
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     tick_valid,
	input  wire logic                     tick_stall,
	input  wire logic        [AXIS_W-1:0] axis,
	input  wire logic        [POS_W-1:0]  target_pos,
	input  wire logic signed [ACT_W-1:0]  actual_pos,
	input  wire logic                     result_valid,
	input  wire logic                     result_stall,
	input  wire logic        [AXIS_W-1:0] axis_out,
	input  wire logic                     settle_done,
	input  wire logic                     out_of_band,
	input  wire logic                     axis_stable,
	input  wire logic                     axis_fault,
	input  wire logic                     all_stable,
	input  wire logic                     any_fault,
	input  wire logic                     psel,
	input  wire logic                     penable,
	input  wire logic                     pwrite,
	input  wire logic        [ADDR_W-1:0] paddr,
	input  wire logic        [DATA_W-1:0] pwdata,
	input  wire logic                     pready,
	output int                            fail_count,
	output int                            pending
);

	typedef struct packed {
		logic [AXIS_W-1:0] ax;
		logic              done;
		logic              oob;
		logic              stab;
		logic              flt;
		logic              all_st;
		logic              any_f;
	} status_t;

	// register copies
	logic [CNT_W-1:0]   cfg_axis_count;
	logic [TIMER_W-1:0] cfg_delay;
	logic [TIMER_W-1:0] cfg_stable;
	logic [TIMER_W-1:0] cfg_fault;
	logic [BAND_W-1:0]  cfg_wband;
	logic [BAND_W-1:0]  cfg_fband;

	// per-axis tracking state
	logic [POS_W-1:0]   last_tgt   [MAX_AXES];
	logic [TIMER_W-1:0] settle_cnt [MAX_AXES];
	logic               settle_run [MAX_AXES];
	logic [TIMER_W-1:0] stable_cnt [MAX_AXES];
	logic [TIMER_W-1:0] fault_cnt  [MAX_AXES];
	logic               settled    [MAX_AXES];
	logic               stable     [MAX_AXES];
	logic               faulted    [MAX_AXES];

	// statuses owed by the block, oldest first
	status_t due_status[$];

	// tick counter that sticks at the limit
	function automatic logic [TIMER_W-1:0] count_up(input logic [TIMER_W-1:0] v);
		return (v >= TIMER_LIMIT) ? TIMER_LIMIT : v + 1'b1;
	endfunction

	// strict tolerance check in exact integer terms, zero band disabled
	function automatic bit outside_band(input longint s, input longint a, input longint b);
		if (b == 0)
			return 1'b0;
		return (a * 10000 < s * (10000 - b)) || (a * 10000 > s * (10000 + b));
	endfunction

	function automatic status_t predict_tick(input logic [AXIS_W-1:0] ax,
			input logic [POS_W-1:0] tgt, input logic signed [ACT_W-1:0] act);
		status_t s;
		bit      checked;
		bit      bad;
		int      n;
		int      i;
		s = '0;
		s.ax = ax;
		checked = 1'b0;
		// new setpoint restarts the settle delay and clears everything
		if (last_tgt[ax] != tgt) begin
			last_tgt[ax]   = tgt;
			settle_cnt[ax] = '0;
			settle_run[ax] = 1'b1;
			settled[ax]    = 1'b0;
			stable_cnt[ax] = '0;
			stable[ax]     = 1'b0;
			fault_cnt[ax]  = '0;
			faulted[ax]    = 1'b0;
		end else if (settled[ax]) begin
			checked = 1'b1;
		end else begin
			if (settle_run[ax])
				settle_cnt[ax] = count_up(settle_cnt[ax]);
			if (cfg_delay <= settle_cnt[ax]) begin
				settle_cnt[ax] = '0;
				settle_run[ax] = 1'b0;
				settled[ax]    = 1'b1;
				checked        = 1'b1;
			end
		end
		// band check once settled
		if (checked) begin
			bad = outside_band(longint'(tgt), longint'(act), longint'(cfg_wband)) ||
			      outside_band(longint'(tgt), longint'(act), longint'(cfg_fband));
			if (bad) begin
				s.oob = 1'b1;
				if (cfg_fault <= fault_cnt[ax]) begin
					fault_cnt[ax] = '0;
					faulted[ax]   = 1'b1;
				end else begin
					fault_cnt[ax] = count_up(fault_cnt[ax]);
				end
				stable_cnt[ax] = '0;
				stable[ax]     = 1'b0;
			end else begin
				if (cfg_stable <= stable_cnt[ax]) begin
					stable_cnt[ax] = '0;
					stable[ax]     = 1'b1;
				end else begin
					stable_cnt[ax] = count_up(stable_cnt[ax]);
				end
				fault_cnt[ax] = '0;
				faulted[ax]   = 1'b0;
			end
		end
		s.done = settled[ax];
		s.stab = stable[ax];
		s.flt  = faulted[ax];
		// summaries over the axes in use
		n = (cfg_axis_count > MAX_AXES) ? MAX_AXES : int'(cfg_axis_count);
		s.all_st = 1'b1;
		s.any_f  = 1'b0;
		for (i = 0; i < n; i++) begin
			if (!stable[i])
				s.all_st = 1'b0;
			if (faulted[i])
				s.any_f = 1'b1;
		end
		return s;
	endfunction

	function automatic void compare_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fail_count++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		status_t want;
		int      i;
		if (!arst_n) begin
			cfg_axis_count = AXIS_COUNT_RST;
			cfg_delay      = CHANGE_DELAY_RST;
			cfg_stable     = STABLE_TIME_RST;
			cfg_fault      = FAULT_TIMEOUT_RST;
			cfg_wband      = BAND_RST;
			cfg_fband      = BAND_RST;
			for (i = 0; i < MAX_AXES; i++) begin
				last_tgt[i]   = '0;
				settle_cnt[i] = '0;
				settle_run[i] = 1'b0;
				stable_cnt[i] = '0;
				fault_cnt[i]  = '0;
				settled[i]    = 1'b0;
				stable[i]     = 1'b0;
				faulted[i]    = 1'b0;
			end
			due_status.delete();
			fail_count = 0;
			pending <= 0;
		end else begin
			// register writes
			if (psel && penable && pwrite && pready) begin
				case (paddr[ADDR_W-1:2])
					REG_AXIS_COUNT:    cfg_axis_count = pwdata[CNT_W-1:0];
					REG_CHANGE_DELAY:  cfg_delay      = pwdata[TIMER_W-1:0];
					REG_STABLE_TIME:   cfg_stable     = pwdata[TIMER_W-1:0];
					REG_FAULT_TIMEOUT: cfg_fault      = pwdata[TIMER_W-1:0];
					REG_WARNING_BAND:  cfg_wband      = pwdata[BAND_W-1:0];
					REG_FAULT_BAND:    cfg_fband      = pwdata[BAND_W-1:0];
					default: ;
				endcase
			end
			// result side
			if (result_valid && !result_stall) begin
				if (due_status.size() == 0) begin
					$error("result for axis %0d with no tick outstanding", axis_out);
					fail_count++;
				end else begin
					want = due_status.pop_front();
					compare_field("axis_out", want.ax, axis_out);
					compare_field("settle_done", want.done, settle_done);
					compare_field("out_of_band", want.oob, out_of_band);
					compare_field("axis_stable", want.stab, axis_stable);
					compare_field("axis_fault", want.flt, axis_fault);
					compare_field("all_stable", want.all_st, all_stable);
					compare_field("any_fault", want.any_f, any_fault);
				end
			end
			// tick side
			if (tick_valid && !tick_stall)
				due_status.push_back(predict_tick(axis, target_pos, actual_pos));
			pending <= due_status.size();
		end
	end

endmodule

/* test/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives monitor ticks and register writes into the axis position settle
// monitor under several idling patterns and settings, and reports the verdict
// from the checker's failure count.
// ----------------------------------------------------------------------------
module tb;
	import apsm_pkg::*;

	localparam logic [2:0] REG_UNUSED     = 3'd6;
	localparam int         WATCHDOG_LIMIT = 3000;
	localparam int         PHASE_ITEMS    = 230;
	localparam int         SAT_ROUNDS     = 5;

	logic                     clk;
	logic                     arst_n       = 1'b0;
	logic                     tick_valid   = 1'b0;
	logic                     tick_stall;
	logic        [AXIS_W-1:0] axis         = '0;
	logic        [POS_W-1:0]  target_pos   = '0;
	logic signed [ACT_W-1:0]  actual_pos   = '0;
	logic                     result_valid;
	logic                     result_stall = 1'b0;
	logic        [AXIS_W-1:0] axis_out;
	logic                     settle_done;
	logic                     out_of_band;
	logic                     axis_stable;
	logic                     axis_fault;
	logic                     all_stable;
	logic                     any_fault;
	logic                     psel         = 1'b0;
	logic                     penable      = 1'b0;
	logic                     pwrite       = 1'b0;
	logic        [ADDR_W-1:0] paddr        = '0;
	logic        [DATA_W-1:0] pwdata       = '0;
	logic        [DATA_W-1:0] prdata;
	logic                     pready;
	int                       fail_count;
	int                       pending;

	// idling controls
	int   idle_pct  = 0;
	int   stall_pct = 0;
	logic long_hold = 1'b0;
	int   hold_left = 0;

	// current band settings and per-axis setpoint plan
	int               cur_wb = 0;
	int               cur_fb = 0;
	logic [POS_W-1:0] goal_tgt [MAX_AXES] = '{default: '0};
	int               aim_dev  [MAX_AXES] = '{default: 0};

	axis_position_settle_monitor dut (.*);
	settle_checker chk (.*);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// receiver: long hold-off on request, otherwise random stalls
	always @(posedge clk) begin
		if (hold_left != 0) begin
			result_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (long_hold) begin
			result_stall <= 1'b1;
			hold_left <= 200;
			long_hold <= 1'b0;
		end else begin
			result_stall <= (int'($urandom_range(99)) < stall_pct);
		end
	end

	// watchdog on cycles with no handshake at all
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (tick_valid && !tick_stall) || (result_valid && !result_stall) ||
			    (psel && penable && pready))
				quiet = 0;
			else
				quiet++;
		end
		$display("RESULT: ERROR");
		$finish;
	end

	task automatic write_reg(input logic [2:0] idx, input logic [DATA_W-1:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// stop offering and wait until every status has come back
	task automatic drain();
		tick_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	task automatic apply_settings(input int cnt, input int delay, input int stab,
			input int flt, input int wb, input int fb);
		drain();
		write_reg(REG_AXIS_COUNT, cnt);
		write_reg(REG_CHANGE_DELAY, delay);
		write_reg(REG_STABLE_TIME, stab);
		write_reg(REG_FAULT_TIMEOUT, flt);
		write_reg(REG_WARNING_BAND, wb);
		write_reg(REG_FAULT_BAND, fb);
		cur_wb = wb;
		cur_fb = fb;
	endtask

	task automatic send_tick(input logic [AXIS_W-1:0] ax, input logic [POS_W-1:0] tgt,
			input logic signed [ACT_W-1:0] act);
		while (int'($urandom_range(99)) < idle_pct) begin
			tick_valid <= 1'b0;
			@(posedge clk);
		end
		tick_valid <= 1'b1;
		axis       <= ax;
		target_pos <= tgt;
		actual_pos <= act;
		@(posedge clk);
		while (tick_stall)
			@(posedge clk);
	endtask

	function automatic logic [POS_W-1:0] pick_target();
		int r;
		r = $urandom_range(99);
		if (r < 10)
			return '0;
		if (r < 15)
			return '1;
		if (r < 55)
			return POS_W'(10000 * $urandom_range(1, 104));
		return POS_W'($urandom_range(0, 1048575));
	endfunction

	function automatic int pick_band();
		int r;
		r = $urandom_range(99);
		if (r < 25)
			return 0;
		if (r < 30)
			return 10000;
		if (r < 35)
			return 16383;
		if (r < 40)
			return 1;
		return $urandom_range(1, 500);
	endfunction

	// one tick: mostly a held setpoint with the measurement drifting around a
	// per-axis offset, so that axes sit in or out of band for a while
	task automatic rand_item();
		logic [AXIS_W-1:0] ax;
		longint            act;
		int                dev;
		int                span;
		ax = AXIS_W'($urandom_range(MAX_AXES - 1));
		if ($urandom_range(99) < 6) begin
			goal_tgt[ax] = pick_target();
			span = (cur_wb > cur_fb) ? cur_wb : cur_fb;
			if (span > 3000)
				span = 3000;
			span = 2 * span + 10;
			if ($urandom_range(1))
				aim_dev[ax] = 0;
			else
				aim_dev[ax] = int'($urandom_range(0, 2 * span)) - span;
		end
		if ($urandom_range(99) < 4) begin
			act = longint'($signed(ACT_W'($urandom)));
		end else begin
			dev = aim_dev[ax] + int'($urandom_range(40)) - 20;
			if ($urandom_range(99) < 10) begin
				dev = $urandom_range(1) ? cur_wb : cur_fb;
				if ($urandom_range(1))
					dev = -dev;
			end
			act = longint'(goal_tgt[ax]) + (longint'(goal_tgt[ax]) * dev) / 10000;
			if ($urandom_range(99) < 10)
				act += longint'($urandom_range(2)) - 1;
		end
		if (act > 1048575)
			act = 1048575;
		if (act < -1048576)
			act = -1048576;
		send_tick(ax, goal_tgt[ax], ACT_W'(act));
	endtask

	initial begin : stimulus
		int p;
		int k;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// default settings: zero delay, bands off, field extremes
		send_tick(3'd0, 20'd0, 21'sd0);
		send_tick(3'd7, 20'd1048575, -21'sd1048576);
		send_tick(3'd7, 20'd1048575, 21'sd1048575);
		send_tick(3'd0, 20'd0, -21'sd1);

		// tight timers, bands of 1% and 0.5%
		apply_settings(8, 2, 1, 1, 100, 50);
		// zero setpoint never seen changing: the axis keeps waiting
		send_tick(3'd5, 20'd0, 21'sd0);
		send_tick(3'd5, 20'd0, 21'sd5);
		// settle, then walk the strict band edges into a fault and out again
		send_tick(3'd3, 20'd1000, 21'sd1000);
		send_tick(3'd3, 20'd1000, 21'sd1000);
		send_tick(3'd3, 20'd1000, 21'sd1000);
		send_tick(3'd3, 20'd1000, 21'sd1005);
		send_tick(3'd3, 20'd1000, 21'sd995);
		send_tick(3'd3, 20'd1000, 21'sd1006);
		send_tick(3'd3, 20'd1000, 21'sd994);
		send_tick(3'd3, 20'd1000, 21'sd1000);
		send_tick(3'd3, 20'd2000, -21'sd1);
		send_tick(3'd3, 20'd2000, -21'sd1);
		send_tick(3'd0, 20'd1048575, 21'sd1048575);
		send_tick(3'd0, 20'd1048575, 21'sd1048575);
		send_tick(3'd0, 20'd1048575, 21'sd1048575);
		send_tick(3'd0, 20'd1048575, 21'sd1048575);

		// random phases over the idling patterns and several settings
		for (p = 0; p < 8; p++) begin
			case (p)
				0: apply_settings(8, 0, 0, 0, 100, 300);
				3: apply_settings(0, 3, 2, 2, 10000, 16383);
				4: apply_settings(15, 99990, 5, 5, 200, 0);
				default: apply_settings($urandom_range(0, 15), $urandom_range(0, 4),
					$urandom_range(0, 6), $urandom_range(0, 6), pick_band(), pick_band());
			endcase
			if (p == 1)
				write_reg(REG_UNUSED, $urandom);
			idle_pct  = (p % 4 == 1) ? 48 : (p % 4 == 3) ? 27 : 0;
			stall_pct = (p % 4 == 2) ? 48 : (p % 4 == 3) ? 27 : 0;
			for (k = 0; k < PHASE_ITEMS; k++) begin
				rand_item();
				if (p == 2 && k == 100)
					long_hold <= 1'b1;
			end
		end

		// unreachable thresholds on held setpoints, then lowered
		idle_pct  = 0;
		stall_pct = 0;
		apply_settings(3, 0, 131071, 131071, 100, 0);
		send_tick(3'd0, 20'd500001, 21'sd500001);
		send_tick(3'd0, 20'd500001, 21'sd500001);
		send_tick(3'd1, 20'd500001, 21'sd0);
		send_tick(3'd1, 20'd500001, 21'sd0);
		drain();
		write_reg(REG_CHANGE_DELAY, 131071);
		send_tick(3'd2, 20'd123457, 21'sd0);
		for (k = 0; k < SAT_ROUNDS; k++) begin
			send_tick(3'd0, 20'd500001, 21'sd500001);
			send_tick(3'd1, 20'd500001, 21'sd0);
			send_tick(3'd2, 20'd123457, 21'sd0);
		end
		drain();
		write_reg(REG_STABLE_TIME, 100000);
		write_reg(REG_FAULT_TIMEOUT, 100000);
		write_reg(REG_CHANGE_DELAY, 99995);
		for (k = 0; k < 3; k++) begin
			send_tick(3'd0, 20'd500001, 21'sd500001);
			send_tick(3'd1, 20'd500001, 21'sd0);
			send_tick(3'd2, 20'd123457, 21'sd0);
		end

		// let the pipe empty and settle
		drain();
		repeat (10) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
